>>> design/sorted_priority_queue_unit_macros.svh
// assertion macros for the sorted priority queue unit
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition in this cycle implies consequence in this cycle
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SPQ_ASSERT_NOW(label, ante, cons, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> design/spq_pkg.sv
package spq_pkg;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int PAYLOAD_BITS  = 32;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      OP_ENQUEUE   = 2'd0,
      OP_DEQUEUE   = 2'd1,
      OP_READ_HEAD = 2'd2,
      OP_NOP       = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [PRIORITY_BITS-1:0] priority_req;
      logic [PAYLOAD_BITS-1:0]  payload;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic                     is_empty;
      logic [PRIORITY_BITS-1:0] head_priority;
      logic [PAYLOAD_BITS-1:0]  head_payload;
   } rsp_type;

   typedef struct packed {
      logic [PRIORITY_BITS-1:0] prio;
      logic [PAYLOAD_BITS-1:0]  data;
   } entry_type;

   // broadcast to every cell in the row
   typedef struct packed {
      logic enqueue;
      logic dequeue;
   } cell_cmd_type;

endpackage

>>> design/spq_cell.sv
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                 occupied,
   input  spq_pkg::entry_type   new_entry,
   input  spq_pkg::entry_type   left_entry,
   input  logic                 left_keep,
   input  spq_pkg::entry_type   right_entry,
   output spq_pkg::entry_type   entry,
   output logic                 keep
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // stays put on insert when it outranks or equals the new entry
   assign keep  = occupied && (entry_ff.prio >= new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.enqueue) begin
         priority if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (cmd.dequeue) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> design/sorted_priority_queue_unit.sv
// sorted priority queue: holds up to CAPACITY entries (priority and payload) in a row of
// cells kept in descending priority order, cell 0 being the head; an entry of equal
// priority lands behind the older ones, so ties leave first in, first out. every request
// word (enqueue, dequeue, read head) gives exactly one response word carrying ok and the
// empty flag after the operation, plus the head entry on a successful read head. each
// operation finishes in the cycle it is accepted: all cells compare against the new
// priority at once and shift left or right together, so one word is taken every clock
// while the output drains, and its response appears in the output register on the next
// cycle. the request side keeps accepting while a response waits, as long as the output
// register is being drained in the same cycle. no clearing pass is needed after reset.
module sorted_priority_queue_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_word
);
   import spq_pkg::*;

   `include "sorted_priority_queue_unit_macros.svh"

   // fill count and response register
   logic [COUNT_BITS-1:0] fill_count_ff;
   logic [COUNT_BITS-1:0] fill_count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_word_ff;
   rsp_type               rsp_word_in;

   // cell row
   entry_type             cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   cell_keep;
   logic [CAPACITY-1:0]   occupied;
   entry_type             new_entry;
   cell_cmd_type          cell_cmd;

   logic                  req_accept;
   logic                  full;
   logic                  empty;
   rsp_type               result;

   // a waiting response blocks only if nobody takes it this cycle
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign full  = (fill_count_ff == COUNT_BITS'(CAPACITY));
   assign empty = (fill_count_ff == '0);

   assign new_entry.prio = req_word.priority_req;
   assign new_entry.data = req_word.payload;

   // failed operations leave the row untouched
   assign cell_cmd.enqueue = req_accept && (req_word.op == OP_ENQUEUE) && !full;
   assign cell_cmd.dequeue = req_accept && (req_word.op == OP_DEQUEUE) && !empty;

   // the row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_entry;
      logic      left_keep;
      entry_type right_entry;

      assign occupied[i] = (COUNT_BITS'(i) < fill_count_ff);

      if (i == 0) begin : g_head
         // an imaginary cell before the head always outranks the new entry
         assign left_entry = new_entry;
         assign left_keep  = 1'b1;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         // the tail slot is beyond the fill count after a dequeue
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .occupied    (occupied[i]),
         .new_entry   (new_entry),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i])
      );
   end

   // fill count follows the successful operations
   always_comb begin
      priority if (cell_cmd.enqueue) begin
         fill_count_in = fill_count_ff + COUNT_BITS'(1);
      end else if (cell_cmd.dequeue) begin
         fill_count_in = fill_count_ff - COUNT_BITS'(1);
      end else begin
         fill_count_in = fill_count_ff;
      end
   end

   // response word for the accepted request
   always_comb begin
      result               = '0;
      result.is_empty      = (fill_count_in == '0);
      unique case (req_word.op)
         OP_ENQUEUE: begin
            result.ok = !full;
         end
         OP_DEQUEUE: begin
            result.ok = !empty;
         end
         OP_READ_HEAD: begin
            if (!empty) begin
               result.ok            = 1'b1;
               result.head_priority = cell_entry[0].prio;
               result.head_payload  = cell_entry[0].data;
            end
         end
         default: begin
            result.ok = 1'b0;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks

   `SPQ_ASSERT_NOW(a_count_bound, 1'b1,
                   fill_count_ff <= COUNT_BITS'(CAPACITY),
                   "fill count over capacity")

   `SPQ_ASSERT_NOW(a_head_order, occupied[1],
                   cell_entry[0].prio >= cell_entry[1].prio,
                   "head out of order")

   `SPQ_ASSERT_NEXT(a_enqueue_count, cell_cmd.enqueue,
                    fill_count_ff == $past(fill_count_ff) + COUNT_BITS'(1),
                    "enqueue did not grow the store")

   `SPQ_ASSERT_NEXT(a_read_head, req_accept && (req_word.op == OP_READ_HEAD) && !empty,
                    rsp_word_ff.ok && (rsp_word_ff.head_payload == $past(cell_entry[0].data)),
                    "read head returned wrong entry")

endmodule
